[src/bsm_pkg.sv]
// shared types, codes and helpers for the bank switch mapper
package bsm_pkg;

    // request opcodes
    localparam logic [2:0] OP_CPU_RD = 3'd0;
    localparam logic [2:0] OP_CPU_WR = 3'd1;
    localparam logic [2:0] OP_PPU_RD = 3'd2;
    localparam logic [2:0] OP_PPU_WR = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    // target memory codes
    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_PRG_RAM = 3'd1;
    localparam logic [2:0] TGT_PRG_ROM = 3'd2;
    localparam logic [2:0] TGT_CHR_ROM = 3'd3;
    localparam logic [2:0] TGT_VRAM    = 3'd4;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANK_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRG_RAM_PRESENT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRG_RAM_MASK    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_SCREEN     = 2'd3;

    // mapper register decode
    localparam logic [15:0] REG_DECODE_MASK = 16'hE001;
    localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
    localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
    localparam logic [15:0] REG_MIRROR      = 16'hA000;
    localparam logic [15:0] REG_PROTECT     = 16'hA001;
    localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
    localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
    localparam logic [15:0] REG_IRQ_DISABLE = 16'hE000;
    localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic        handled;
        logic [2:0]  target_memory;
        logic [18:0] mapped_address;
        logic        write_strobe;
        logic        irq_line_out;
        logic        ciram_ce_out;
        logic        ciram_a10_out;
    } rsp_t;

    // access part of a result
    typedef struct packed {
        logic        handled;
        logic [2:0]  target;
        logic [18:0] mapped;
        logic        strobe;
    } map_t;

    // register writes decoded from a cpu request
    typedef struct packed {
        logic       bank_select_we;
        logic       bank_data_we;
        logic       mirror_we;
        logic       latch_we;
        logic       count_clear;
        logic       irq_disable;
        logic       irq_enable;
        logic [7:0] data;
        logic [7:0] bank_data;
    } cpu_wr_t;

    // state updates from a ppu request or tick
    typedef struct packed {
        logic       sample;
        logic       a12_next;
        logic [7:0] count_next;
        logic       irq_set;
        logic       ce_we;
        logic       ce;
        logic       a10_we;
        logic       a10;
    } ppu_upd_t;

    typedef logic [7:0][7:0] bank_file_t;

    function automatic logic [7:0] bank_data_mask(input logic [2:0] target);
        logic [7:0] m;
        case (target)
            3'd0, 3'd1: m = 8'hFE;
            3'd6, 3'd7: m = 8'h3F;
            default:    m = 8'hFF;
        endcase
        return m;
    endfunction

endpackage

[src/bsm_cpu_map.sv]
// cpu side: prg window mapping and mapper register write decode
module bsm_cpu_map (
    input  bsm_pkg::req_t       req,
    input  logic [6:0]          prg_bank_count,
    input  logic                prg_ram_present,
    input  logic [12:0]         prg_ram_addr_mask,
    input  logic [7:0]          bank_select,
    input  bsm_pkg::bank_file_t bank_regs,
    output bsm_pkg::map_t       map,
    output bsm_pkg::cpu_wr_t    wr
);

    logic [15:0] addr;
    logic [15:0] base;
    logic [5:0]  bank;
    logic [6:0]  n_m1;
    logic [6:0]  n_m2;
    logic        is_rd;
    logic        is_wr;
    logic        in_ram;
    logic        in_rom;

    always_comb
    begin
        addr   = req.bus_address;
        is_rd  = (req.opcode == bsm_pkg::OP_CPU_RD);
        is_wr  = (req.opcode == bsm_pkg::OP_CPU_WR);
        in_ram = (addr[15:13] == 3'b011);
        in_rom = addr[15];

        // prg mode swaps the 0x8000 and 0xc000 windows
        base = addr & 16'hE000;
        if (bank_select[6] && (base == 16'h8000 || base == 16'hC000))
        begin
            base = base ^ 16'h4000;
        end
        n_m1 = prg_bank_count - 7'd1;
        n_m2 = prg_bank_count - 7'd2;
        case (base[14:13])
            2'b00:   bank = n_m1[5:0] & bank_regs[6][5:0];
            2'b01:   bank = n_m1[5:0] & bank_regs[7][5:0];
            2'b10:   bank = n_m2[5:0];
            default: bank = n_m1[5:0];
        endcase

        map = '0;
        wr  = '0;
        wr.data      = req.write_data;
        wr.bank_data = req.write_data & bsm_pkg::bank_data_mask(bank_select[2:0]);

        if (is_rd || is_wr)
        begin
            if (in_ram)
            begin
                if (prg_ram_present)
                begin
                    map.handled = 1'b1;
                    map.target  = bsm_pkg::TGT_PRG_RAM;
                    map.mapped  = {6'd0, addr[12:0] & prg_ram_addr_mask};
                    map.strobe  = is_wr;
                end
            end
            else if (in_rom)
            begin
                map.handled = 1'b1;
                if (is_rd)
                begin
                    map.target = bsm_pkg::TGT_PRG_ROM;
                    map.mapped = {bank, addr[12:0]};
                end
                else
                begin
                    case (addr & bsm_pkg::REG_DECODE_MASK)
                        bsm_pkg::REG_BANK_SELECT: wr.bank_select_we = 1'b1;
                        bsm_pkg::REG_BANK_DATA:   wr.bank_data_we   = 1'b1;
                        bsm_pkg::REG_MIRROR:      wr.mirror_we      = 1'b1;
                        bsm_pkg::REG_IRQ_LATCH:   wr.latch_we       = 1'b1;
                        bsm_pkg::REG_IRQ_RELOAD:  wr.count_clear    = 1'b1;
                        bsm_pkg::REG_IRQ_DISABLE: wr.irq_disable    = 1'b1;
                        bsm_pkg::REG_IRQ_ENABLE:  wr.irq_enable     = 1'b1;
                        default:                  wr.irq_enable     = 1'b0;
                    endcase
                end
            end
        end
    end

endmodule

[src/bsm_ppu_map.sv]
// ppu side: chr banking, nametable routing and a12 edge counter
module bsm_ppu_map #(
    parameter int EXT_VRAM_BYTES = 4096
) (
    input  bsm_pkg::req_t       req,
    input  logic                four_screen,
    input  logic                mirror_horizontal,
    input  logic                chr_invert,
    input  bsm_pkg::bank_file_t bank_regs,
    input  logic                last_a12,
    input  logic [7:0]          irq_count,
    input  logic [7:0]          irq_latch,
    input  logic                irq_enabled,
    output bsm_pkg::map_t       map,
    output bsm_pkg::ppu_upd_t   upd
);

    localparam logic [15:0] VRAM_MASK = 16'(EXT_VRAM_BYTES - 1);

    logic [15:0] addr;
    logic [15:0] sel;
    logic [7:0]  bank;
    logic [7:0]  cnt_dec;
    logic        is_rd;
    logic        is_wr;
    logic        is_tick;

    always_comb
    begin
        addr    = req.bus_address;
        is_rd   = (req.opcode == bsm_pkg::OP_PPU_RD);
        is_wr   = (req.opcode == bsm_pkg::OP_PPU_WR);
        is_tick = (req.opcode == bsm_pkg::OP_TICK);
        cnt_dec = irq_count - 8'd1;

        upd            = '0;
        upd.sample     = is_rd || is_wr || is_tick;
        upd.a12_next   = addr[12];
        upd.count_next = irq_count;
        // rising a12: a zero counter reloads, otherwise count down, raising the irq at zero if enabled
        if (upd.sample && !last_a12 && addr[12])
        begin
            if (irq_count == 8'd0)
            begin
                upd.count_next = irq_latch;
            end
            else
            begin
                upd.count_next = cnt_dec;
                upd.irq_set    = (cnt_dec == 8'd0) && irq_enabled;
            end
        end

        sel = chr_invert ? (addr ^ 16'h1000) : addr;
        case (sel[12:10])
            3'd0:    bank = bank_regs[0];
            3'd1:    bank = bank_regs[0] + 8'd1;
            3'd2:    bank = bank_regs[1];
            3'd3:    bank = bank_regs[1] + 8'd1;
            3'd4:    bank = bank_regs[2];
            3'd5:    bank = bank_regs[3];
            3'd6:    bank = bank_regs[4];
            default: bank = bank_regs[5];
        endcase

        map = '0;
        if (is_rd || is_wr)
        begin
            upd.ce_we = 1'b1;
            if (addr[15:13] != 3'd0)
            begin
                if (four_screen)
                begin
                    upd.ce      = 1'b0;
                    map.handled = 1'b1;
                    map.target  = bsm_pkg::TGT_VRAM;
                    map.mapped  = {3'd0, addr & VRAM_MASK};
                    map.strobe  = is_wr;
                end
                else
                begin
                    upd.ce     = 1'b1;
                    upd.a10_we = 1'b1;
                    upd.a10    = mirror_horizontal ? addr[11] : addr[10];
                end
            end
            else
            begin
                upd.ce = 1'b0;
                if (is_rd)
                begin
                    map.handled = 1'b1;
                    map.target  = bsm_pkg::TGT_CHR_ROM;
                    map.mapped  = {1'b0, bank, addr[9:0]};
                end
            end
        end
    end

endmodule

[src/bank_switch_mapper_with_scanline_irq.sv]
// top level of the bank switch mapper with scanline interrupt counter
//
// requests arrive on req (valid/ready): cpu read or write, ppu read or write,
// or a tick that samples the ppu address. each request gives exactly one
// response on rsp (valid/ready) with the mapped target, address, write strobe
// and the irq and nametable lines as they stand after that request.
// rsp_valid rises in the cycle after acceptance, with only the response
// register between the request and the response; one request is taken every
// cycle while that register is not stalled.
// while rsp_ready is low the response register holds and req_ready drops
// only when that register is full and not being drained.
// configuration (cfg_we, cfg_index, cfg_data) is written in one cycle and is
// to be changed only while no request is in flight.
// rst_n clears all mapper state to zero, loads the configuration defaults
// (64 prg banks, prg-ram present, full ram mask, no four-screen ram) and
// empties the response register.
module bank_switch_mapper_with_scanline_irq #(
    parameter int EXT_VRAM_BYTES = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  bsm_pkg::req_t                   req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output bsm_pkg::rsp_t                   rsp,
    input  logic                            cfg_we,
    input  logic [bsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [6:0]  prg_bank_count_reg;
    logic        prg_ram_present_reg;
    logic [12:0] prg_ram_addr_mask_reg;
    logic        four_screen_reg;

    logic [7:0]          bank_select_reg, bank_select_next;
    bsm_pkg::bank_file_t bank_regs_reg, bank_regs_next;
    logic                mirror_reg, mirror_next;
    logic                irq_enabled_reg, irq_enabled_next;
    logic [7:0]          irq_latch_reg, irq_latch_next;
    logic [7:0]          irq_count_reg, irq_count_next;
    logic                last_a12_reg, last_a12_next;
    logic                irq_pending_reg, irq_pending_next;
    logic                ciram_ce_reg, ciram_ce_next;
    logic                ciram_a10_reg, ciram_a10_next;

    logic          rsp_valid_reg;
    bsm_pkg::rsp_t rsp_reg, rsp_next;

    logic              accept;
    bsm_pkg::map_t     cpu_map;
    bsm_pkg::map_t     ppu_map;
    bsm_pkg::map_t     map;
    bsm_pkg::cpu_wr_t  wr;
    bsm_pkg::ppu_upd_t upd;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    bsm_cpu_map u_cpu_map (
        .req               (req),
        .prg_bank_count    (prg_bank_count_reg),
        .prg_ram_present   (prg_ram_present_reg),
        .prg_ram_addr_mask (prg_ram_addr_mask_reg),
        .bank_select       (bank_select_reg),
        .bank_regs         (bank_regs_reg),
        .map               (cpu_map),
        .wr                (wr)
    );

    bsm_ppu_map #(
        .EXT_VRAM_BYTES (EXT_VRAM_BYTES)
    ) u_ppu_map (
        .req               (req),
        .four_screen       (four_screen_reg),
        .mirror_horizontal (mirror_reg),
        .chr_invert        (bank_select_reg[7]),
        .bank_regs         (bank_regs_reg),
        .last_a12          (last_a12_reg),
        .irq_count         (irq_count_reg),
        .irq_latch         (irq_latch_reg),
        .irq_enabled       (irq_enabled_reg),
        .map               (ppu_map),
        .upd               (upd)
    );

    // each side gives an all-zero map for opcodes it does not own
    assign map = bsm_pkg::map_t'(cpu_map | ppu_map);

    always_comb
    begin
        bank_select_next = bank_select_reg;
        bank_regs_next   = bank_regs_reg;
        mirror_next      = mirror_reg;
        irq_enabled_next = irq_enabled_reg;
        irq_latch_next   = irq_latch_reg;
        irq_count_next   = irq_count_reg;
        last_a12_next    = last_a12_reg;
        irq_pending_next = irq_pending_reg;
        ciram_ce_next    = ciram_ce_reg;
        ciram_a10_next   = ciram_a10_reg;

        if (wr.bank_select_we)
        begin
            bank_select_next = wr.data;
        end
        if (wr.bank_data_we)
        begin
            bank_regs_next[bank_select_reg[2:0]] = wr.bank_data;
        end
        if (wr.mirror_we)
        begin
            mirror_next = wr.data[0];
        end
        if (wr.latch_we)
        begin
            irq_latch_next = wr.data;
        end
        if (wr.count_clear)
        begin
            irq_count_next = 8'd0;
        end
        else if (upd.sample)
        begin
            irq_count_next = upd.count_next;
        end
        if (upd.sample)
        begin
            last_a12_next = upd.a12_next;
        end
        if (wr.irq_disable)
        begin
            irq_enabled_next = 1'b0;
            irq_pending_next = 1'b0;
        end
        else if (wr.irq_enable)
        begin
            irq_enabled_next = 1'b1;
        end
        if (upd.irq_set)
        begin
            irq_pending_next = 1'b1;
        end
        if (upd.ce_we)
        begin
            ciram_ce_next = upd.ce;
        end
        if (upd.a10_we)
        begin
            ciram_a10_next = upd.a10;
        end

        rsp_next.handled        = map.handled;
        rsp_next.target_memory  = map.target;
        rsp_next.mapped_address = map.mapped;
        rsp_next.write_strobe   = map.strobe;
        rsp_next.irq_line_out   = irq_pending_next;
        rsp_next.ciram_ce_out   = ciram_ce_next;
        rsp_next.ciram_a10_out  = ciram_a10_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_bank_count_reg    <= 7'd64;
            prg_ram_present_reg   <= 1'b1;
            prg_ram_addr_mask_reg <= 13'h1FFF;
            four_screen_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsm_pkg::CFG_PRG_BANK_COUNT:  prg_bank_count_reg    <= cfg_data[6:0];
                bsm_pkg::CFG_PRG_RAM_PRESENT: prg_ram_present_reg   <= cfg_data[0];
                bsm_pkg::CFG_PRG_RAM_MASK:    prg_ram_addr_mask_reg <= cfg_data[12:0];
                bsm_pkg::CFG_FOUR_SCREEN:     four_screen_reg       <= cfg_data[0];
                default:                      four_screen_reg       <= four_screen_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_select_reg <= '0;
            bank_regs_reg   <= '0;
            mirror_reg      <= 1'b0;
            irq_enabled_reg <= 1'b0;
            irq_latch_reg   <= '0;
            irq_count_reg   <= '0;
            last_a12_reg    <= 1'b0;
            irq_pending_reg <= 1'b0;
            ciram_ce_reg    <= 1'b0;
            ciram_a10_reg   <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                bank_select_reg <= bank_select_next;
                bank_regs_reg   <= bank_regs_next;
                mirror_reg      <= mirror_next;
                irq_enabled_reg <= irq_enabled_next;
                irq_latch_reg   <= irq_latch_next;
                irq_count_reg   <= irq_count_next;
                last_a12_reg    <= last_a12_next;
                irq_pending_reg <= irq_pending_next;
                ciram_ce_reg    <= ciram_ce_next;
                ciram_a10_reg   <= ciram_a10_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

[src/bsm_check.sv]
// port-level checks for the bank switch mapper, bound to the top level
module bsm_check (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input bsm_pkg::rsp_t rsp
);

    // no target means no address and no write
    a_none_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.target_memory == bsm_pkg::TGT_NONE
        |-> rsp.mapped_address == 19'd0 && !rsp.write_strobe)
        else $error("response without target carries address or strobe");

    // a claimed target is always a handled request
    a_target_handled: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.target_memory != bsm_pkg::TGT_NONE |-> rsp.handled)
        else $error("target given for an unhandled request");

    // only the ram targets are ever written
    a_strobe_ram_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.write_strobe
        |-> rsp.target_memory == bsm_pkg::TGT_PRG_RAM
            || rsp.target_memory == bsm_pkg::TGT_VRAM)
        else $error("write strobe towards read-only memory");

    // four-screen ram access leaves the console nametable disabled
    a_vram_no_ciram: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.target_memory == bsm_pkg::TGT_VRAM |-> !rsp.ciram_ce_out)
        else $error("console nametable enabled on four-screen access");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

endmodule

bind bank_switch_mapper_with_scanline_irq bsm_check u_bsm_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

[sim/mapper_checker.sv]
// request/response checker for the bank switch mapper: predicts every response and compares it
`timescale 1ns / 100ps

module mapper_checker #(
    parameter int VRAM_BYTES = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    input  logic                            req_ready,
    input  bsm_pkg::req_t                   req,
    input  logic                            rsp_valid,
    input  logic                            rsp_ready,
    input  bsm_pkg::rsp_t                   rsp,
    input  logic                            cfg_we,
    input  logic [bsm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsm_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              in_flight,
    output int                              failures
);

    // configuration copy
    logic [6:0]  rom_banks;
    logic        ram_fitted;
    logic [12:0] ram_mask;
    logic        four_screen;

    // mapper state copy
    logic [7:0]  sel_reg;
    logic [7:0]  bank_reg [8];
    logic        mirror_h;
    logic        irq_on;
    logic [7:0]  latch_val;
    logic [7:0]  counter;
    logic        a12_prev;
    logic        irq_flag;
    logic        nt_enable;
    logic        nt_a10;

    bsm_pkg::rsp_t due_rsp [$];
    bsm_pkg::rsp_t want;
    int            mismatches = 0;

    function automatic void track_a12(input logic [15:0] addr);
        if (!a12_prev && addr[12])
        begin
            if (counter == 8'd0)
            begin
                counter = latch_val;
            end
            else
            begin
                counter = counter - 8'd1;
                if (counter == 8'd0 && irq_on)
                    irq_flag = 1'b1;
            end
        end
        a12_prev = addr[12];
    endfunction

    function automatic logic [5:0] prg_window(input logic [15:0] addr);
        logic [15:0] base;
        logic [5:0]  last;
        base = addr & 16'hE000;
        last = rom_banks[5:0] - 6'd1;
        if (sel_reg[6] && (base == 16'h8000 || base == 16'hC000))
            base = base ^ 16'h4000;
        case (base)
            16'h8000: return last & bank_reg[6][5:0];
            16'hA000: return last & bank_reg[7][5:0];
            16'hC000: return rom_banks[5:0] - 6'd2;
            default:  return last;
        endcase
    endfunction

    function automatic logic [7:0] chr_page(input logic [15:0] addr);
        logic [15:0] sel;
        sel = sel_reg[7] ? (addr ^ 16'h1000) : addr;
        case (sel[12:10])
            3'd0:    return bank_reg[0];
            3'd1:    return bank_reg[0] + 8'd1;
            3'd2:    return bank_reg[1];
            3'd3:    return bank_reg[1] + 8'd1;
            3'd4:    return bank_reg[2];
            3'd5:    return bank_reg[3];
            3'd6:    return bank_reg[4];
            default: return bank_reg[5];
        endcase
    endfunction

    function automatic void write_mapper_reg(input logic [15:0] addr, input logic [7:0] value);
        logic [7:0] keep;
        case (sel_reg[2:0])
            3'd0, 3'd1: keep = 8'hFE;
            3'd6, 3'd7: keep = 8'h3F;
            default:    keep = 8'hFF;
        endcase
        case (addr & bsm_pkg::REG_DECODE_MASK)
            bsm_pkg::REG_BANK_SELECT: sel_reg = value;
            bsm_pkg::REG_BANK_DATA:   bank_reg[sel_reg[2:0]] = value & keep;
            bsm_pkg::REG_MIRROR:      mirror_h = value[0];
            bsm_pkg::REG_IRQ_LATCH:   latch_val = value;
            bsm_pkg::REG_IRQ_RELOAD:  counter = 8'd0;
            bsm_pkg::REG_IRQ_DISABLE:
            begin
                irq_on = 1'b0;
                irq_flag = 1'b0;
            end
            bsm_pkg::REG_IRQ_ENABLE:  irq_on = 1'b1;
            default: ;
        endcase
    endfunction

    function automatic bsm_pkg::rsp_t predict_access(input bsm_pkg::req_t r);
        bsm_pkg::rsp_t o;
        logic [15:0]   a;
        o = '0;
        a = r.bus_address;
        case (r.opcode)
            bsm_pkg::OP_CPU_RD, bsm_pkg::OP_CPU_WR:
            begin
                if (a >= 16'h6000 && a < 16'h8000)
                begin
                    if (ram_fitted)
                    begin
                        o.handled = 1'b1;
                        o.target_memory = bsm_pkg::TGT_PRG_RAM;
                        o.mapped_address = 19'(a[12:0] & ram_mask);
                        o.write_strobe = (r.opcode == bsm_pkg::OP_CPU_WR);
                    end
                end
                else if (a >= 16'h8000)
                begin
                    o.handled = 1'b1;
                    if (r.opcode == bsm_pkg::OP_CPU_RD)
                    begin
                        o.target_memory = bsm_pkg::TGT_PRG_ROM;
                        o.mapped_address = {prg_window(a), a[12:0]};
                    end
                    else
                    begin
                        write_mapper_reg(a, r.write_data);
                    end
                end
            end
            bsm_pkg::OP_PPU_RD, bsm_pkg::OP_PPU_WR:
            begin
                track_a12(a);
                if (a >= 16'h2000)
                begin
                    if (four_screen)
                    begin
                        nt_enable = 1'b0;
                        o.handled = 1'b1;
                        o.target_memory = bsm_pkg::TGT_VRAM;
                        o.mapped_address = 19'(a & 16'(VRAM_BYTES - 1));
                        o.write_strobe = (r.opcode == bsm_pkg::OP_PPU_WR);
                    end
                    else
                    begin
                        nt_enable = 1'b1;
                        nt_a10 = mirror_h ? a[11] : a[10];
                    end
                end
                else
                begin
                    nt_enable = 1'b0;
                    if (r.opcode == bsm_pkg::OP_PPU_RD)
                    begin
                        o.handled = 1'b1;
                        o.target_memory = bsm_pkg::TGT_CHR_ROM;
                        o.mapped_address = {1'b0, chr_page(a), a[9:0]};
                    end
                end
            end
            bsm_pkg::OP_TICK: track_a12(a);
            default: ;
        endcase
        o.irq_line_out = irq_flag;
        o.ciram_ce_out = nt_enable;
        o.ciram_a10_out = nt_a10;
        return o;
    endfunction

    task automatic check_field(input string field, input logic [18:0] expected_val,
                               input logic [18:0] actual_val);
        if (expected_val !== actual_val)
        begin
            $error("%s: expected %0h, got %0h", field, expected_val, actual_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_banks = 7'd64;
            ram_fitted = 1'b1;
            ram_mask = 13'h1FFF;
            four_screen = 1'b0;
            sel_reg = '0;
            for (int i = 0; i < 8; i++)
                bank_reg[i] = '0;
            mirror_h = 1'b0;
            irq_on = 1'b0;
            latch_val = '0;
            counter = '0;
            a12_prev = 1'b0;
            irq_flag = 1'b0;
            nt_enable = 1'b0;
            nt_a10 = 1'b0;
            due_rsp.delete();
            in_flight <= 0;
            failures <= mismatches;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bsm_pkg::CFG_PRG_BANK_COUNT:  rom_banks = cfg_data[6:0];
                    bsm_pkg::CFG_PRG_RAM_PRESENT: ram_fitted = cfg_data[0];
                    bsm_pkg::CFG_PRG_RAM_MASK:    ram_mask = cfg_data[12:0];
                    bsm_pkg::CFG_FOUR_SCREEN:     four_screen = cfg_data[0];
                    default: ;
                endcase
            end
            if (rsp_valid && rsp_ready)
            begin
                if (due_rsp.size() == 0)
                begin
                    $error("response with no request waiting");
                    mismatches++;
                end
                else
                begin
                    want = due_rsp.pop_front();
                    check_field("handled", 19'(want.handled), 19'(rsp.handled));
                    check_field("target_memory", 19'(want.target_memory),
                                19'(rsp.target_memory));
                    check_field("mapped_address", want.mapped_address, rsp.mapped_address);
                    check_field("write_strobe", 19'(want.write_strobe),
                                19'(rsp.write_strobe));
                    check_field("irq_line_out", 19'(want.irq_line_out),
                                19'(rsp.irq_line_out));
                    check_field("ciram_ce_out", 19'(want.ciram_ce_out),
                                19'(rsp.ciram_ce_out));
                    check_field("ciram_a10_out", 19'(want.ciram_a10_out),
                                19'(rsp.ciram_a10_out));
                end
            end
            if (req_valid && req_ready)
                due_rsp.push_back(predict_access(req));
            in_flight <= due_rsp.size();
            failures <= mismatches;
        end
    end

endmodule

[sim/testbench.sv]
// top of the mapper testbench: clock, reset, request and config stimulus, verdict
`timescale 1ns / 100ps

module testbench;

    localparam int VRAM_BYTES = 4096;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 275;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_ready;
    bsm_pkg::req_t                   req = '0;
    logic                            rsp_valid;
    logic                            rsp_ready = 1'b0;
    bsm_pkg::rsp_t                   rsp;
    logic                            cfg_we = 1'b0;
    logic [bsm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bsm_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    int                              in_flight;
    int                              failures;

    bit send_fast = 1'b0;
    bit drain_fast = 1'b0;
    bit a12_phase = 1'b0;

    // settings per phase; phase 0 runs on the reset defaults
    int phase_banks [PHASES] = '{64, 2, 48, 32, 64, 8};
    int phase_ram   [PHASES] = '{1, 0, 1, 1, 1, 0};
    int phase_mask  [PHASES] = '{8191, 0, 2047, 0, 8191, 8191};
    int phase_four  [PHASES] = '{0, 1, 0, 1, 1, 0};

    always #1 clk = ~clk;

    bank_switch_mapper_with_scanline_irq #(
        .EXT_VRAM_BYTES(VRAM_BYTES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    mapper_checker #(
        .VRAM_BYTES(VRAM_BYTES)
    ) u_mapper_checker (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_flight(in_flight),
        .failures(failures)
    );

    function automatic bsm_pkg::req_t access_of(input logic [2:0] op, input logic [15:0] addr,
                                                input logic [7:0] data);
        bsm_pkg::req_t a;
        a.opcode = op;
        a.bus_address = addr;
        a.write_data = data;
        return a;
    endfunction

    // mostly flips a12 so that the scanline counter sees plenty of rising edges
    function automatic logic next_a12();
        if ($urandom_range(0, 3) != 0)
            a12_phase = !a12_phase;
        return a12_phase;
    endfunction

    function automatic bsm_pkg::req_t random_access();
        bsm_pkg::req_t a;
        int            roll;
        logic [15:0]   base;
        roll = $urandom_range(0, 99);
        a.write_data = 8'($urandom);
        a.bus_address = 16'($urandom);
        if (roll < 22)
        begin
            a.opcode = bsm_pkg::OP_CPU_WR;
            case ($urandom_range(0, 3))
                0:       base = bsm_pkg::REG_BANK_SELECT;
                1:       base = bsm_pkg::REG_MIRROR;
                2:       base = bsm_pkg::REG_IRQ_LATCH;
                default: base = bsm_pkg::REG_IRQ_DISABLE;
            endcase
            a.bus_address = base | (a.bus_address & 16'h1FFF);
            // short latch values let the counter run out often
            if ((a.bus_address & bsm_pkg::REG_DECODE_MASK) == bsm_pkg::REG_IRQ_LATCH
                && $urandom_range(0, 3) != 0)
                a.write_data = 8'($urandom_range(0, 7));
        end
        else if (roll < 40)
        begin
            a.opcode = bsm_pkg::OP_CPU_RD;
            case ($urandom_range(0, 3))
                0, 1:    a.bus_address[15] = 1'b1;
                2:       a.bus_address[15:13] = 3'b011;
                default: ;
            endcase
        end
        else if (roll < 46)
        begin
            a.opcode = bsm_pkg::OP_CPU_WR;
            a.bus_address[15] = 1'b0;
        end
        else if (roll < 72)
        begin
            a.opcode = $urandom_range(0, 1) ? bsm_pkg::OP_PPU_RD : bsm_pkg::OP_PPU_WR;
            if ($urandom_range(0, 1))
                a.bus_address[15:14] = 2'b00;
            a.bus_address[12] = next_a12();
        end
        else if (roll < 96)
        begin
            a.opcode = bsm_pkg::OP_TICK;
            a.bus_address[12] = next_a12();
        end
        else
        begin
            a.opcode = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
        end
        return a;
    endfunction

    task automatic issue(input bsm_pkg::req_t item);
        int gap;
        gap = send_fast ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do @(posedge clk); while (!req_ready);
        if ($urandom_range(0, 39) == 0)
            send_fast = !send_fast;
    endtask

    task automatic write_reg(input logic [bsm_pkg::CFG_INDEX_W-1:0] index, input int value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= bsm_pkg::CFG_DATA_W'(value);
        @(posedge clk);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0)
            @(posedge clk);
    endtask

    // response side: random stalls with bursts of none
    initial
    begin
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = drain_fast ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!(rsp_valid && rsp_ready));
            if ($urandom_range(0, 39) == 0)
                drain_fast = !drain_fast;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (!rst_n)
            @(posedge clk);

        // prg-ram window edges and low addresses
        issue(access_of(bsm_pkg::OP_CPU_RD, 16'h0000, 8'h00));
        issue(access_of(bsm_pkg::OP_CPU_RD, 16'h5FFF, 8'hFF));
        issue(access_of(bsm_pkg::OP_CPU_WR, 16'h6000, 8'hA5));
        issue(access_of(bsm_pkg::OP_CPU_RD, 16'h7FFF, 8'h00));
        // prg bank registers with swapped mode, full masks
        issue(access_of(bsm_pkg::OP_CPU_WR, bsm_pkg::REG_BANK_SELECT, 8'h46));
        issue(access_of(bsm_pkg::OP_CPU_WR, bsm_pkg::REG_BANK_DATA, 8'hFF));
        issue(access_of(bsm_pkg::OP_CPU_WR, bsm_pkg::REG_BANK_SELECT, 8'h47));
        issue(access_of(bsm_pkg::OP_CPU_WR, bsm_pkg::REG_BANK_DATA, 8'h05));
        issue(access_of(bsm_pkg::OP_CPU_RD, 16'h8000, 8'h00));
        issue(access_of(bsm_pkg::OP_CPU_RD, 16'hBFFF, 8'h00));
        issue(access_of(bsm_pkg::OP_CPU_RD, 16'hC000, 8'h00));
        issue(access_of(bsm_pkg::OP_CPU_RD, 16'hFFFF, 8'h00));
        // chr inversion and 2 KiB bank masking
        issue(access_of(bsm_pkg::OP_CPU_WR, bsm_pkg::REG_BANK_SELECT, 8'h80));
        issue(access_of(bsm_pkg::OP_CPU_WR, bsm_pkg::REG_BANK_DATA, 8'hFF));
        issue(access_of(bsm_pkg::OP_PPU_RD, 16'h1000, 8'h00));
        issue(access_of(bsm_pkg::OP_PPU_RD, 16'h07FF, 8'h00));
        issue(access_of(bsm_pkg::OP_PPU_WR, 16'h0400, 8'h3C));
        // horizontal mirroring, protect register ignored
        issue(access_of(bsm_pkg::OP_CPU_WR, bsm_pkg::REG_MIRROR, 8'h01));
        issue(access_of(bsm_pkg::OP_CPU_WR, bsm_pkg::REG_PROTECT, 8'hFF));
        issue(access_of(bsm_pkg::OP_PPU_RD, 16'h2C00, 8'h00));
        // scanline counter: reload on first edge, then count down to the irq
        issue(access_of(bsm_pkg::OP_CPU_WR, bsm_pkg::REG_IRQ_LATCH, 8'h01));
        issue(access_of(bsm_pkg::OP_CPU_WR, bsm_pkg::REG_IRQ_RELOAD, 8'h00));
        issue(access_of(bsm_pkg::OP_CPU_WR, bsm_pkg::REG_IRQ_ENABLE, 8'h00));
        issue(access_of(bsm_pkg::OP_TICK, 16'h1000, 8'h00));
        issue(access_of(bsm_pkg::OP_TICK, 16'h0000, 8'h00));
        issue(access_of(bsm_pkg::OP_PPU_WR, 16'h3FFF, 8'h00));
        issue(access_of(bsm_pkg::OP_CPU_WR, bsm_pkg::REG_IRQ_DISABLE, 8'h00));
        issue(access_of(OP_SPARE_LAST, 16'hFFFF, 8'hFF));

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_idle();
                write_reg(bsm_pkg::CFG_PRG_BANK_COUNT, phase_banks[p]);
                write_reg(bsm_pkg::CFG_PRG_RAM_PRESENT, phase_ram[p]);
                write_reg(bsm_pkg::CFG_PRG_RAM_MASK, phase_mask[p]);
                write_reg(bsm_pkg::CFG_FOUR_SCREEN, phase_four[p]);
                cfg_we <= 1'b0;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                issue(random_access());
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
src/bsm_pkg.sv
src/bsm_cpu_map.sv
src/bsm_ppu_map.sv
src/bank_switch_mapper_with_scanline_irq.sv
src/bsm_check.sv
sim/mapper_checker.sv
sim/testbench.sv
